[src/cdt_pkg.sv]
// Shared types, event codes and helper functions for the countdown timer.
`timescale 1ns / 1ps

package cdt_pkg;

  localparam int KIND_W      = 3;
  localparam int DIGIT_W     = 4;
  localparam int FIELD_W     = 7;
  localparam int FIELD_COUNT = 3;
  localparam int CURSOR_W    = 2;
  localparam int MODE_W      = 2;

  localparam logic [KIND_W-1:0] KIND_DIGIT  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_NEXT   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PREV   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_BUTTON = 3'd3;
  localparam logic [KIND_W-1:0] KIND_TICK   = 3'd4;

  localparam logic [CURSOR_W-1:0] CURSOR_SEC  = 2'd0;
  localparam logic [CURSOR_W-1:0] CURSOR_MIN  = 2'd1;
  localparam logic [CURSOR_W-1:0] CURSOR_HOUR = 2'd2;

  localparam logic [MODE_W-1:0] MODE_CODE_SET   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CODE_RUN   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CODE_ALARM = 2'd2;

  localparam logic [FIELD_W-1:0] RELOAD    = 7'd59;
  localparam logic [FIELD_W-1:0] FIELD_MAX = 7'd99;
  localparam logic [DIGIT_W-1:0] BASE      = 4'd10;

  typedef enum logic [2:0] {
    MODE_SET   = 3'b001,
    MODE_RUN   = 3'b010,
    MODE_ALARM = 3'b100
  } mode_t;

  typedef struct packed {
    logic [FIELD_COUNT-1:0][FIELD_W-1:0] fields;
    logic [CURSOR_W-1:0]                 cursor;
    mode_t                               mode;
  } timer_state_t;

  function automatic logic [MODE_W-1:0] mode_code(input mode_t m);
    case (m)
      MODE_RUN:   mode_code = MODE_CODE_RUN;
      MODE_ALARM: mode_code = MODE_CODE_ALARM;
      default:    mode_code = MODE_CODE_SET;
    endcase
  endfunction

  function automatic logic [3:0] low_digit(input logic [FIELD_W-1:0] v);
    logic [14:0]        prod;
    logic [3:0]         q;
    logic [FIELD_W-1:0] qten;
    logic [FIELD_W-1:0] rem;
    prod = {8'd0, v} * 15'd205;
    q = prod[14:11];
    qten = {q, 3'b000} + {2'b00, q, 1'b0};
    rem = v - qten;
    low_digit = rem[3:0];
  endfunction

  function automatic logic [FIELD_W-1:0] shift_in(input logic [FIELD_W-1:0] v,
                                                  input logic [DIGIT_W-1:0] d);
    logic [3:0] r;
    r = low_digit(v);
    shift_in = {r, 3'b000} + {2'b00, r, 1'b0} + {3'b000, d};
  endfunction

endpackage

[src/cdt_update.sv]
// Next-state logic for one timer event.
`timescale 1ns / 1ps

module cdt_update (
  input  cdt_pkg::timer_state_t              cur,
  input  logic [cdt_pkg::KIND_W-1:0]         kind,
  input  logic [cdt_pkg::DIGIT_W-1:0]        digit,
  output cdt_pkg::timer_state_t              nxt
);

  logic [cdt_pkg::FIELD_COUNT-1:0][cdt_pkg::FIELD_W-1:0] ticked;
  logic [cdt_pkg::FIELD_W-1:0] sel_field;
  logic [cdt_pkg::FIELD_W-1:0] shifted;
  logic                        cur_zero;
  logic                        ticked_zero;

  always_comb begin
    case (cur.cursor)
      cdt_pkg::CURSOR_SEC: sel_field = cur.fields[0];
      cdt_pkg::CURSOR_MIN: sel_field = cur.fields[1];
      default:             sel_field = cur.fields[2];
    endcase
  end

  assign shifted  = cdt_pkg::shift_in(sel_field, digit);
  assign cur_zero = (cur.fields[0] == '0) && (cur.fields[1] == '0) && (cur.fields[2] == '0);

  always_comb begin
    ticked = cur.fields;
    if (cur.fields[0] != '0) begin
      ticked[0] = cur.fields[0] - 7'd1;
    end else if (cur.fields[1] != '0) begin
      ticked[1] = cur.fields[1] - 7'd1;
      ticked[0] = cdt_pkg::RELOAD;
    end else if (cur.fields[2] != '0) begin
      ticked[2] = cur.fields[2] - 7'd1;
      ticked[1] = cdt_pkg::RELOAD;
      ticked[0] = cdt_pkg::RELOAD;
    end
  end

  assign ticked_zero = (ticked[0] == '0) && (ticked[1] == '0) && (ticked[2] == '0);

  always_comb begin
    nxt = cur;
    case (cur.mode)
      cdt_pkg::MODE_SET: begin
        case (kind)
          cdt_pkg::KIND_DIGIT: begin
            if (digit < cdt_pkg::BASE) begin
              case (cur.cursor)
                cdt_pkg::CURSOR_SEC: nxt.fields[0] = shifted;
                cdt_pkg::CURSOR_MIN: nxt.fields[1] = shifted;
                default:             nxt.fields[2] = shifted;
              endcase
            end
          end
          cdt_pkg::KIND_NEXT: begin
            if (cur.cursor < cdt_pkg::CURSOR_HOUR) nxt.cursor = cur.cursor + 2'd1;
          end
          cdt_pkg::KIND_PREV: begin
            if (cur.cursor > cdt_pkg::CURSOR_SEC) nxt.cursor = cur.cursor - 2'd1;
          end
          cdt_pkg::KIND_BUTTON: begin
            nxt.mode = cur_zero ? cdt_pkg::MODE_ALARM : cdt_pkg::MODE_RUN;
          end
          default: ;
        endcase
      end
      cdt_pkg::MODE_RUN: begin
        if (kind == cdt_pkg::KIND_TICK) begin
          nxt.fields = ticked;
          if (ticked_zero) nxt.mode = cdt_pkg::MODE_ALARM;
        end
      end
      cdt_pkg::MODE_ALARM: begin
        if (kind == cdt_pkg::KIND_BUTTON) begin
          nxt.mode   = cdt_pkg::MODE_SET;
          nxt.cursor = cdt_pkg::CURSOR_SEC;
        end
      end
      default: ;
    endcase
  end

endmodule

[src/countdown_timer_with_digit_entry.sv]
// Top level of the countdown timer: input register, timer state and result beat.
//
// Input channel (in_valid, in_stall, kind, digit) carries one event per beat:
// a digit key, next or previous field, a button press or a one-second tick.
// Output channel (out_valid, out_stall, seconds, minutes, hours, cursor, mode)
// returns one beat per event showing the timer after that event.
// Path: an accepted event is registered in the input register and its result
// is then loaded into the timer state register, which offers the result beat;
// an output stall can hold the event in the input register in between.
// Throughput: one event per cycle while not stalled; the input register and
// state register form two stages, the input loading when empty or on advance.
// Stall: while out_stall holds a result, the result and timer state hold;
// one more event may wait in the input register, after which in_stall rises.
// Reset (rst, synchronous): fields clear to zero, cursor to seconds, mode to
// setting; both stages empty.
`timescale 1ns / 1ps

module countdown_timer_with_digit_entry (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [cdt_pkg::KIND_W-1:0]        kind,
  input  logic [cdt_pkg::DIGIT_W-1:0]       digit,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [cdt_pkg::FIELD_W-1:0]       seconds,
  output logic [cdt_pkg::FIELD_W-1:0]       minutes,
  output logic [cdt_pkg::FIELD_W-1:0]       hours,
  output logic [cdt_pkg::CURSOR_W-1:0]      cursor,
  output logic [cdt_pkg::MODE_W-1:0]        mode
);

  logic                         held_valid;
  logic [cdt_pkg::KIND_W-1:0]   held_kind;
  logic [cdt_pkg::DIGIT_W-1:0]  held_digit;
  cdt_pkg::timer_state_t        st;
  cdt_pkg::timer_state_t        st_next;
  logic                         advance;
  logic                         load_in;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = held_valid && !advance;
  assign load_in  = !held_valid || advance;

  cdt_update u_update (
    .cur   (st),
    .kind  (held_kind),
    .digit (held_digit),
    .nxt   (st_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (load_in) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_in && in_valid) begin
      held_kind  <= kind;
      held_digit <= digit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.fields <= '0;
      st.cursor <= cdt_pkg::CURSOR_SEC;
      st.mode   <= cdt_pkg::MODE_SET;
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= held_valid;
      if (held_valid) st <= st_next;
    end
  end

  assign seconds = st.fields[0];
  assign minutes = st.fields[1];
  assign hours   = st.fields[2];
  assign cursor  = st.cursor;
  assign mode    = cdt_pkg::mode_code(st.mode);

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall && held_valid))
    else $error("input stalled while pipeline can advance");

  a_alarm_at_zero: assert property (@(posedge clk) disable iff (rst)
    (st.mode == cdt_pkg::MODE_ALARM) |-> (st.fields == '0))
    else $error("alarm with nonzero time");

  a_cursor_frozen_running: assert property (@(posedge clk) disable iff (rst)
    (st.mode == cdt_pkg::MODE_RUN) |=> $stable(st.cursor))
    else $error("cursor moved while counting");

  a_fields_in_range: assert property (@(posedge clk) disable iff (rst)
    (st.fields[0] <= cdt_pkg::FIELD_MAX) && (st.fields[1] <= cdt_pkg::FIELD_MAX)
    && (st.fields[2] <= cdt_pkg::FIELD_MAX))
    else $error("field value above two digits");

endmodule
